/* rtl/bcc_pkg.sv */
// ----------------------------------------------------------------------------
// bcc_pkg: shared types and constants of the button click classifier
// Holds the per-key state record, the configuration record, the step and mode
// codes, and the register map of the configuration port.
// ----------------------------------------------------------------------------
package bcc_pkg;

  localparam int NUM_KEYS   = 3;
  localparam int TIMER_BITS = 16;
  localparam int KEY_W      = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  // Key bits carried by the input fields and reported by the output fields.
  localparam int IN_KEYS  = 3;
  localparam int OUT_KEYS = 3;

  localparam int CFG_W    = 12;
  localparam int PADDR_W  = 5;
  localparam int PDATA_W  = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SHORT    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LONG     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DOUBLE   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SINGLE   = 3'd4;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 12'd5;
  localparam logic [CFG_W-1:0] SHORT_RST    = 12'd200;
  localparam logic [CFG_W-1:0] LONG_RST     = 12'd500;
  localparam logic [CFG_W-1:0] DOUBLE_RST   = 12'd300;
  localparam logic [CFG_W-1:0] SINGLE_RST   = 12'd150;

  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_SINGLE = 2'd1;
  localparam logic [1:0] MODE_LONG   = 2'd2;
  localparam logic [1:0] MODE_DOUBLE = 2'd3;

  typedef enum logic [2:0] {
    STEP_IDLE     = 3'd0,
    STEP_DEBOUNCE = 3'd1,
    STEP_HELD     = 3'd2,
    STEP_WAIT2    = 3'd3,
    STEP_RELEASE  = 3'd4
  } step_t;

  typedef struct packed {
    step_t                 step;
    logic [TIMER_BITS-1:0] timer;
    logic                  timing;
    logic [1:0]            mode_lat;
    logic [1:0]            mode_cur;
    logic                  single_l;
    logic                  double_l;
    logic                  long_l;
  } key_state_t;

  localparam int STATE_W = $bits(key_state_t);

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ticks;
    logic [CFG_W-1:0] short_ticks;
    logic [CFG_W-1:0] long_ticks;
    logic [CFG_W-1:0] double_ticks;
    logic [CFG_W-1:0] single_ticks;
  } cfg_t;

endpackage

/* rtl/bcc_ram.sv */
// ----------------------------------------------------------------------------
// bcc_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module bcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/bcc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// bcc_cfg_regs: configuration registers behind the APB-style port
// Five 12-bit timing thresholds, one per word; writes beyond the map are
// ignored and read back as zero.
// ----------------------------------------------------------------------------
module bcc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bcc_pkg::PADDR_W-1:0]   paddr,
  input  logic [bcc_pkg::PDATA_W-1:0]   pwdata,
  output logic [bcc_pkg::PDATA_W-1:0]   prdata,
  output bcc_pkg::cfg_t                 cfg
);

  logic                              wr_en;
  logic [bcc_pkg::REG_IDX_W-1:0]     idx;
  logic [bcc_pkg::CFG_W-1:0]         wval;
  logic [bcc_pkg::CFG_W-1:0]         rval;

  assign wr_en = psel && penable && pwrite;
  assign idx   = paddr[bcc_pkg::PADDR_W-1:2];
  assign wval  = pwdata[bcc_pkg::CFG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks <= bcc_pkg::DEBOUNCE_RST;
      cfg.short_ticks    <= bcc_pkg::SHORT_RST;
      cfg.long_ticks     <= bcc_pkg::LONG_RST;
      cfg.double_ticks   <= bcc_pkg::DOUBLE_RST;
      cfg.single_ticks   <= bcc_pkg::SINGLE_RST;
    end else if (wr_en) begin
      case (idx)
        bcc_pkg::REG_DEBOUNCE: cfg.debounce_ticks <= wval;
        bcc_pkg::REG_SHORT:    cfg.short_ticks    <= wval;
        bcc_pkg::REG_LONG:     cfg.long_ticks     <= wval;
        bcc_pkg::REG_DOUBLE:   cfg.double_ticks   <= wval;
        bcc_pkg::REG_SINGLE:   cfg.single_ticks   <= wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      bcc_pkg::REG_DEBOUNCE: rval = cfg.debounce_ticks;
      bcc_pkg::REG_SHORT:    rval = cfg.short_ticks;
      bcc_pkg::REG_LONG:     rval = cfg.long_ticks;
      bcc_pkg::REG_DOUBLE:   rval = cfg.double_ticks;
      bcc_pkg::REG_SINGLE:   rval = cfg.single_ticks;
      default:               rval = '0;
    endcase
  end

  assign prdata = bcc_pkg::PDATA_W'(rval);

endmodule

/* rtl/bcc_key_update.sv */
// ----------------------------------------------------------------------------
// bcc_key_update: one tick of one key's click classifier
// Takes the key's stored record and this tick's level and clear bit, and
// returns the record to write back.
// ----------------------------------------------------------------------------
module bcc_key_update (
  input  bcc_pkg::key_state_t cur,
  input  logic                rel,
  input  logic                clr,
  input  bcc_pkg::cfg_t       cfg,
  output bcc_pkg::key_state_t nxt
);

  localparam logic [bcc_pkg::TIMER_BITS-1:0] TMAX = '1;

  logic [bcc_pkg::TIMER_BITS-1:0] t;
  logic [bcc_pkg::TIMER_BITS-1:0] deb_t;
  logic [bcc_pkg::TIMER_BITS-1:0] short_t;
  logic [bcc_pkg::TIMER_BITS-1:0] long_t;
  logic [bcc_pkg::TIMER_BITS-1:0] double_t;
  logic [bcc_pkg::TIMER_BITS-1:0] single_t;

  assign deb_t    = bcc_pkg::TIMER_BITS'(cfg.debounce_ticks);
  assign short_t  = bcc_pkg::TIMER_BITS'(cfg.short_ticks);
  assign long_t   = bcc_pkg::TIMER_BITS'(cfg.long_ticks);
  assign double_t = bcc_pkg::TIMER_BITS'(cfg.double_ticks);
  assign single_t = bcc_pkg::TIMER_BITS'(cfg.single_ticks);

  // The timer saturates while timing and reads zero otherwise.
  assign t = !cur.timing ? '0 :
             (cur.timer != TMAX) ? cur.timer + bcc_pkg::TIMER_BITS'(1) : cur.timer;

  always_comb begin
    nxt       = cur;
    nxt.timer = t;
    if (clr) begin
      nxt.single_l = 1'b0;
      nxt.double_l = 1'b0;
      nxt.long_l   = 1'b0;
    end

    // Long press is declared once the running timer reaches the long threshold.
    if (cur.timing && (t >= long_t) && !nxt.long_l) begin
      nxt.long_l   = 1'b1;
      nxt.mode_lat = bcc_pkg::MODE_LONG;
      nxt.mode_cur = bcc_pkg::MODE_LONG;
      nxt.step     = bcc_pkg::STEP_IDLE;
      nxt.timing   = 1'b0;
    end

    case (nxt.step)
      bcc_pkg::STEP_IDLE: begin
        if (!rel) begin
          nxt.step   = bcc_pkg::STEP_DEBOUNCE;
          nxt.timing = 1'b1;
        end else begin
          nxt.mode_cur = bcc_pkg::MODE_NONE;
        end
      end
      bcc_pkg::STEP_DEBOUNCE: begin
        if ((t > deb_t) && !rel) begin
          nxt.step = bcc_pkg::STEP_HELD;
        end
      end
      bcc_pkg::STEP_HELD: begin
        if (rel) begin
          if (t < short_t) begin
            nxt.step = bcc_pkg::STEP_WAIT2;
          end
          if (t > long_t) begin
            nxt.step     = bcc_pkg::STEP_IDLE;
            nxt.timing   = 1'b0;
            nxt.long_l   = 1'b1;
            nxt.mode_lat = bcc_pkg::MODE_LONG;
            nxt.mode_cur = bcc_pkg::MODE_LONG;
          end
        end
      end
      bcc_pkg::STEP_WAIT2: begin
        if (!rel && (t < double_t)) begin
          nxt.step     = bcc_pkg::STEP_RELEASE;
          nxt.timing   = 1'b0;
          nxt.double_l = 1'b1;
          nxt.mode_lat = bcc_pkg::MODE_DOUBLE;
          nxt.mode_cur = bcc_pkg::MODE_DOUBLE;
        end else if (rel && (t >= single_t)) begin
          nxt.step     = bcc_pkg::STEP_RELEASE;
          nxt.timing   = 1'b0;
          nxt.single_l = 1'b1;
          nxt.mode_lat = bcc_pkg::MODE_SINGLE;
          nxt.mode_cur = bcc_pkg::MODE_SINGLE;
        end
      end
      bcc_pkg::STEP_RELEASE: begin
        if (rel) begin
          nxt.step = bcc_pkg::STEP_IDLE;
        end
      end
      default: ;
    endcase
  end

endmodule

/* rtl/button_click_classifier.sv */
// ----------------------------------------------------------------------------
// button_click_classifier: single, double and long press detector
// Each input transfer is one millisecond tick carrying the key levels and the
// latch clear mask; each tick yields one output transfer with the latched and
// current modes and the event latches of every key.
// ----------------------------------------------------------------------------
//
//   channel   handshake            payload
//   --------  -------------------  ---------------------------------------------
//   input     in_valid / in_ready  key_levels[2:0], clear_flags[2:0]
//   output    out_valid/out_ready  mode_bits, mode_now_bits, single/double/long
//   config    psel/penable/pready  paddr, pwdata, prdata (five 12-bit words)
//
// The per-key state RAM is read one key per cycle, and each key is written back
// in the next cycle; the next tick starts only after the last key of the
// previous tick has been written back.
// An input transfer is held in a one-entry buffer, so a tick is accepted while
// the previous one is being processed or its result waits at the output.
// Reset is synchronous; the state RAM needs no clearing pass, since a valid
// bit per key makes an unwritten entry read as the reset record.
// A stalled output holds the next tick in the input buffer; no work is lost.
// ----------------------------------------------------------------------------
module button_click_classifier (
  input  logic                        clk,
  input  logic                        rst,
  // Tick input
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  key_levels,
  input  logic [2:0]                  clear_flags,
  // Result output
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [5:0]                  mode_bits,
  output logic [5:0]                  mode_now_bits,
  output logic [2:0]                  single_latches,
  output logic [2:0]                  double_latches,
  output logic [2:0]                  long_latches,
  // Configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bcc_pkg::PADDR_W-1:0] paddr,
  input  logic [bcc_pkg::PDATA_W-1:0] pwdata,
  output logic [bcc_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int KW = bcc_pkg::KEY_W;
  localparam logic [KW-1:0] LAST_KEY = KW'(bcc_pkg::NUM_KEYS - 1);

  bcc_pkg::cfg_t cfg;

  // Input buffer.
  logic       hold_valid;
  logic [2:0] hold_levels;
  logic [2:0] hold_clears;

  // Key sequencer.
  logic          start;
  logic          inflight;
  logic          seq_busy;
  logic [KW-1:0] seq_key;
  logic [2:0]    seq_levels;
  logic [2:0]    seq_clears;

  // Read issue.
  logic          rd_en;
  logic [KW-1:0] rd_key;
  logic [2:0]    rd_levels;
  logic [2:0]    rd_clears;
  logic          rd_rel;
  logic          rd_clr;

  // Modify/write stage.
  logic                      m_valid;
  logic [KW-1:0]             m_key;
  logic                      m_rel;
  logic                      m_clr;
  logic                      m_last;
  logic                      m_vld;
  logic                      fwd_hit;
  bcc_pkg::key_state_t       fwd_data;
  logic [bcc_pkg::STATE_W-1:0] ram_rdata;
  bcc_pkg::key_state_t       cur_state;
  bcc_pkg::key_state_t       new_state;

  logic [bcc_pkg::NUM_KEYS-1:0] entry_valid;

  assign pready = 1'b1;

  bcc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // A tick starts only when nothing is in flight and the output register will
  // be free by the time its last key is written back.
  assign start    = hold_valid && !inflight && (!out_valid || out_ready);
  assign in_ready = !hold_valid || start;

  assign rd_en     = start || seq_busy;
  assign rd_key    = start ? '0 : seq_key;
  assign rd_levels = start ? hold_levels : seq_levels;
  assign rd_clears = start ? hold_clears : seq_clears;

  // Keys without an input bit read as released and are never cleared.
  always_comb begin
    rd_rel = 1'b1;
    rd_clr = 1'b0;
    for (int i = 0; i < bcc_pkg::IN_KEYS; i++) begin
      if ((i < bcc_pkg::NUM_KEYS) && (rd_key == KW'(i))) begin
        rd_rel = rd_levels[i];
        rd_clr = rd_clears[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      inflight   <= 1'b0;
      seq_busy   <= 1'b0;
      seq_key    <= '0;
      m_valid    <= 1'b0;
      fwd_hit    <= 1'b0;
      out_valid  <= 1'b0;
      entry_valid <= '0;
    end else begin
      if (in_valid && in_ready) begin
        hold_valid <= 1'b1;
      end else if (start) begin
        hold_valid <= 1'b0;
      end

      if (start) begin
        inflight <= 1'b1;
        seq_busy <= (bcc_pkg::NUM_KEYS > 1);
        seq_key  <= KW'(1);
      end else begin
        if (m_valid && m_last) begin
          inflight <= 1'b0;
        end
        if (seq_busy) begin
          if (seq_key == LAST_KEY) begin
            seq_busy <= 1'b0;
          end else begin
            seq_key <= seq_key + KW'(1);
          end
        end
      end

      m_valid <= rd_en;
      // The RAM returns old data when read and written at once, so the
      // record being written is forwarded to the next cycle.
      fwd_hit <= rd_en && m_valid && (m_key == rd_key);

      if (m_valid) begin
        entry_valid[m_key] <= 1'b1;
      end

      if (m_valid && m_last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_levels <= key_levels;
      hold_clears <= clear_flags;
    end
    if (start) begin
      seq_levels <= hold_levels;
      seq_clears <= hold_clears;
    end
    m_key    <= rd_key;
    m_rel    <= rd_rel;
    m_clr    <= rd_clr;
    m_last   <= (rd_key == LAST_KEY);
    m_vld    <= entry_valid[rd_key];
    fwd_data <= new_state;
  end

  bcc_ram #(
    .WIDTH (bcc_pkg::STATE_W),
    .DEPTH (bcc_pkg::NUM_KEYS)
  ) u_state_ram (
    .clk   (clk),
    .we    (m_valid),
    .waddr (m_key),
    .wdata (new_state),
    .re    (rd_en),
    .raddr (rd_key),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (fwd_hit) begin
      cur_state = fwd_data;
    end else if (m_vld) begin
      cur_state = bcc_pkg::key_state_t'(ram_rdata);
    end else begin
      cur_state = '0;
    end
  end

  bcc_key_update u_update (
    .cur (cur_state),
    .rel (m_rel),
    .clr (m_clr),
    .cfg (cfg),
    .nxt (new_state)
  );

  // Result fields are filled key by key as each key is written back; the
  // output register is empty while a tick is in flight.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_bits      <= '0;
      mode_now_bits  <= '0;
      single_latches <= '0;
      double_latches <= '0;
      long_latches   <= '0;
    end else if (m_valid) begin
      for (int i = 0; i < bcc_pkg::OUT_KEYS; i++) begin
        if ((i < bcc_pkg::NUM_KEYS) && (m_key == KW'(i))) begin
          mode_bits[2*i +: 2]     <= new_state.mode_lat;
          mode_now_bits[2*i +: 2] <= new_state.mode_cur;
          single_latches[i]       <= new_state.single_l;
          double_latches[i]       <= new_state.double_l;
          long_latches[i]         <= new_state.long_l;
        end
      end
    end
  end

`ifndef ASSERT_OFF
  // The last key of a tick is written back only into an empty output register.
  assert property (@(posedge clk) disable iff (rst)
    (m_valid && m_last) |-> !out_valid)
    else $error("result overwrites a pending output transfer");

  // A result appears only right after the last key of a tick was processed.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(m_valid && m_last))
    else $error("output transfer without a completed tick");

  // Keys of one tick are read in consecutive cycles without a gap.
  assert property (@(posedge clk) disable iff (rst)
    (m_valid && !m_last) |-> rd_en)
    else $error("key sequence of a tick was interrupted");

  // A new tick never starts while another is still being processed.
  assert property (@(posedge clk) disable iff (rst)
    m_valid |-> (inflight && !start))
    else $error("tick started while keys are still in flight");
`endif

endmodule
